// ===== hw/rtl/i2a_pkg.sv =====
// ---------------------------------------------------------------------------
// i2a_pkg
// Types and constants shared by the integer to ASCII formatter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    // Width of the integer that is converted
    localparam int VALUE_BITS  = 32;
    // Decimal digits needed for the widest magnitude
    localparam int DIGIT_DEPTH = VALUE_BITS * 31 / 100 + 1;
    // Hex digits in one value, and the value padded to whole nibbles
    localparam int NIB_COUNT   = (VALUE_BITS + 3) / 4;
    localparam int PAD_BITS    = NIB_COUNT * 4;
    localparam int HEX_BITS    = DIGIT_DEPTH * 4;
    // Index into the digit store and conversion step counter widths
    localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
    localparam int STEP_W      = (NIB_COUNT > 1) ? $clog2(NIB_COUNT) : 1;

    localparam int DEC_RADIX   = 10;

    // ASCII codes
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_X     = 7'h78;
    localparam logic [6:0] CHAR_A_LC  = 7'h61;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         hex_mode;
    } in_item_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } out_item_t;

    // Source of the next output character
    typedef enum logic [1:0] {
        SEL_MINUS,
        SEL_ZERO,
        SEL_X,
        SEL_DIGIT
    } emit_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      load;
        logic      step;
        logic      count;
        logic      emit;
        emit_sel_t sel;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic neg;
        logic hex;
        logic step_done;
        logic last_digit;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2a_datapath.sv =====
// ---------------------------------------------------------------------------
// i2a_datapath
// Magnitude register, BCD digit store with four shift-add-3 steps per cycle,
// leading digit search and the output character register.
// ---------------------------------------------------------------------------
`default_nettype none

module i2a_datapath
    import i2a_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  in_data,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    output out_item_t      out_data
);

    logic [PAD_BITS-1:0]    mag_reg;
    logic [PAD_BITS-1:0]    mag_next;
    logic [3:0]             digit_reg [DIGIT_DEPTH];
    logic [3:0]             digit_next [DIGIT_DEPTH];
    logic                   hex_reg;
    logic                   neg_reg;
    logic [STEP_W-1:0]      step_cnt_reg;
    logic [DIGIT_IDX_W-1:0] emit_pos_reg;
    logic [DIGIT_IDX_W-1:0] emit_pos_next;
    out_item_t              out_reg;
    out_item_t              out_next;

    logic [VALUE_BITS-1:0]  raw_value;
    logic                   in_neg;
    logic [VALUE_BITS-1:0]  in_mag;
    logic [HEX_BITS-1:0]    hex_vec;
    logic [3:0]             dab [DIGIT_DEPTH];
    logic [PAD_BITS-1:0]    mag_shift;
    logic [DIGIT_IDX_W-1:0] top_idx;
    logic [3:0]             cur_digit;
    logic [6:0]             digit_char;

    // Decode the input value
    assign raw_value = in_data.value;
    assign in_neg    = raw_value[VALUE_BITS-1] & ~in_data.hex_mode;
    assign in_mag    = in_neg ? (~raw_value + 1'b1) : raw_value;
    assign hex_vec   = HEX_BITS'(raw_value);

    // Four double-dabble steps: adjust every digit, then shift one bit in
    always_comb
    begin
        mag_shift = mag_reg;
        for (int i = 0; i < DIGIT_DEPTH; i++)
        begin
            dab[i] = digit_reg[i];
        end
        for (int b = 0; b < 4; b++)
        begin
            for (int i = 0; i < DIGIT_DEPTH; i++)
            begin
                if (dab[i] >= 4'd5)
                begin
                    dab[i] = dab[i] + 4'd3;
                end
            end
            for (int i = DIGIT_DEPTH - 1; i > 0; i--)
            begin
                dab[i] = {dab[i][2:0], dab[i-1][3]};
            end
            dab[0]    = {dab[0][2:0], mag_shift[PAD_BITS-1]};
            mag_shift = mag_shift << 1;
        end
    end

    // Find the most significant nonzero digit
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < DIGIT_DEPTH; i++)
        begin
            if (digit_reg[i] != 4'd0)
            begin
                top_idx = DIGIT_IDX_W'(i);
            end
        end
    end

    // Digit to ASCII
    assign cur_digit  = digit_reg[emit_pos_reg];
    assign digit_char = (cur_digit < 4'(DEC_RADIX))
                        ? (CHAR_ZERO + {3'b000, cur_digit})
                        : (CHAR_A_LC + {3'b000, cur_digit} - 7'(DEC_RADIX));

    // Next values of the digit store and magnitude
    always_comb
    begin
        mag_next = mag_reg;
        for (int i = 0; i < DIGIT_DEPTH; i++)
        begin
            digit_next[i] = digit_reg[i];
        end
        if (cmd.load)
        begin
            mag_next = PAD_BITS'(in_mag);
            for (int i = 0; i < DIGIT_DEPTH; i++)
            begin
                digit_next[i] = in_data.hex_mode ? hex_vec[4*i +: 4] : 4'd0;
            end
        end
        else if (cmd.step)
        begin
            mag_next = mag_shift;
            for (int i = 0; i < DIGIT_DEPTH; i++)
            begin
                digit_next[i] = dab[i];
            end
        end
    end

    // Next emit position and output character
    always_comb
    begin
        emit_pos_next = emit_pos_reg;
        out_next      = out_reg;
        if (cmd.count)
        begin
            emit_pos_next = top_idx;
        end
        if (cmd.emit)
        begin
            out_next.last_char = 1'b0;
            case (cmd.sel)
                SEL_MINUS: out_next.char_code = CHAR_MINUS;
                SEL_ZERO:  out_next.char_code = CHAR_ZERO;
                SEL_X:     out_next.char_code = CHAR_X;
                default:
                begin
                    out_next.char_code = digit_char;
                    out_next.last_char = (emit_pos_reg == '0);
                    if (emit_pos_reg != '0)
                    begin
                        emit_pos_next = emit_pos_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        out_reg <= out_next;
        for (int i = 0; i < DIGIT_DEPTH; i++)
        begin
            digit_reg[i] <= digit_next[i];
        end
    end

    // Hold per-item control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_reg      <= 1'b0;
            neg_reg      <= 1'b0;
            step_cnt_reg <= '0;
            emit_pos_reg <= '0;
        end
        else
        begin
            emit_pos_reg <= emit_pos_next;
            if (cmd.load)
            begin
                hex_reg      <= in_data.hex_mode;
                neg_reg      <= in_neg;
                step_cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
        end
    end

    assign stat.neg        = neg_reg;
    assign stat.hex        = hex_reg;
    assign stat.step_done  = (step_cnt_reg == STEP_W'(NIB_COUNT - 1));
    assign stat.last_digit = (emit_pos_reg == '0);
    assign out_data        = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/i2a_ctrl.sv =====
// ---------------------------------------------------------------------------
// i2a_ctrl
// Sequencer for one conversion: load, convert, find length, then emit the
// prefix and digits through the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module i2a_ctrl
    import i2a_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_PRE1,
        ST_PRE2,
        ST_DIGITS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_emit;

    // Output slot is free or drains this cycle
    assign can_emit = ~out_valid_reg | out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Commands and next state
    always_comb
    begin
        cmd        = '{load: 1'b0, step: 1'b0, count: 1'b0, emit: 1'b0, sel: SEL_DIGIT};
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Hex digits are loaded directly; decimal runs the BCD steps
                if (stat.hex)
                begin
                    state_next = ST_COUNT;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.step_done)
                    begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT:
            begin
                cmd.count = 1'b1;
                state_next = (stat.hex || stat.neg) ? ST_PRE1 : ST_DIGITS;
            end
            ST_PRE1:
            begin
                if (can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = stat.hex ? SEL_ZERO : SEL_MINUS;
                    state_next = stat.hex ? ST_PRE2 : ST_DIGITS;
                end
            end
            ST_PRE2:
            begin
                if (can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_X;
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_DIGIT;
                    if (stat.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on emit, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Never overwrite a character that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("character emitted over a stalled output");

    // The final digit leaves the block idle with the character on offer
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.sel == SEL_DIGIT && stat.last_digit)
        |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("conversion did not end after its last digit");

    // No new item while a conversion is under way
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!cmd.emit && !cmd.step && state_reg == ST_IDLE))
        else $error("item loaded during a conversion");

    // The final BCD step hands over to the length search
    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.step_done) |=> (state_reg == ST_COUNT))
        else $error("conversion steps overran");

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter
// Converts a signed integer to decimal or 0x-prefixed hex ASCII text.
// ---------------------------------------------------------------------------
// One item is converted at a time. After the input is taken, a decimal value
// passes through the conversion state, where the BCD converter shifts four
// bits per cycle, and then the state that finds its leading digit; a hex
// value is loaded directly but passes through both states as well. The text
// then leaves one character per cycle while the output is ready. The last
// character of the text carries last_char. The input is taken again once
// the last character sits in the output register.
`default_nettype none

module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    i2a_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    i2a_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
